>>> src/iwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package iwd_pkg;

    localparam logic [6:0] OP_INVALID      = 7'd0;
    localparam logic [6:0] OP_NOP          = 7'd1;
    localparam logic [6:0] OP_SLL          = 7'd2;
    localparam logic [6:0] OP_SRL          = 7'd3;
    localparam logic [6:0] OP_SRA          = 7'd4;
    localparam logic [6:0] OP_SLLV         = 7'd5;
    localparam logic [6:0] OP_SRLV         = 7'd6;
    localparam logic [6:0] OP_SRAV         = 7'd7;
    localparam logic [6:0] OP_JR           = 7'd8;
    localparam logic [6:0] OP_JALR         = 7'd9;
    localparam logic [6:0] OP_SYSCALL      = 7'd10;
    localparam logic [6:0] OP_BREAK        = 7'd11;
    localparam logic [6:0] OP_SYNC         = 7'd12;
    localparam logic [6:0] OP_MFHI         = 7'd13;
    localparam logic [6:0] OP_MTHI         = 7'd14;
    localparam logic [6:0] OP_MFLO         = 7'd15;
    localparam logic [6:0] OP_MTLO         = 7'd16;
    localparam logic [6:0] OP_MULT         = 7'd17;
    localparam logic [6:0] OP_MULTU        = 7'd18;
    localparam logic [6:0] OP_DIV          = 7'd19;
    localparam logic [6:0] OP_DIVU         = 7'd20;
    localparam logic [6:0] OP_ADD          = 7'd21;
    localparam logic [6:0] OP_SLT          = 7'd29;
    localparam logic [6:0] OP_SLTU         = 7'd30;
    localparam logic [6:0] OP_BLTZ         = 7'd31;
    localparam logic [6:0] OP_J            = 7'd32;
    localparam logic [6:0] OP_BGEZ         = 7'd33;
    localparam logic [6:0] OP_BLTZAL       = 7'd34;
    localparam logic [6:0] OP_JAL          = 7'd35;
    localparam logic [6:0] OP_BGEZAL       = 7'd36;
    localparam logic [6:0] OP_BEQ          = 7'd37;
    localparam logic [6:0] OP_BNE          = 7'd38;
    localparam logic [6:0] OP_BLEZ         = 7'd39;
    localparam logic [6:0] OP_BGTZ         = 7'd40;
    localparam logic [6:0] OP_ADDI         = 7'd41;
    localparam logic [6:0] OP_SB           = 7'd56;
    localparam logic [6:0] OP_SH           = 7'd57;
    localparam logic [6:0] OP_SWL          = 7'd58;
    localparam logic [6:0] OP_SW           = 7'd59;
    localparam logic [6:0] OP_SWR          = 7'd60;
    localparam logic [6:0] OP_SC           = 7'd61;
    localparam logic [6:0] OP_LL           = 7'd62;
    localparam logic [6:0] OP_RDHWR_TLS    = 7'd63;
    localparam logic [6:0] OP_SWC1         = 7'd64;
    localparam logic [6:0] OP_LWC1         = 7'd65;
    localparam logic [6:0] OP_BC1T         = 7'd66;
    localparam logic [6:0] OP_BC1F         = 7'd67;
    localparam logic [6:0] OP_MFC1         = 7'd68;
    localparam logic [6:0] OP_CFC1         = 7'd69;
    localparam logic [6:0] OP_MTC1         = 7'd70;
    localparam logic [6:0] OP_CTC1         = 7'd71;
    localparam logic [6:0] OP_ADD_F32      = 7'd72;
    localparam logic [6:0] OP_ADD_F64      = 7'd73;
    localparam logic [6:0] OP_SUB_F32      = 7'd74;
    localparam logic [6:0] OP_ABS_F32      = 7'd80;
    localparam logic [6:0] OP_CVT_F64_F32  = 7'd86;
    localparam logic [6:0] OP_CVT_F64_I32  = 7'd87;
    localparam logic [6:0] OP_CVT_F32_F64  = 7'd88;
    localparam logic [6:0] OP_CVT_F32_I32  = 7'd89;
    localparam logic [6:0] OP_CVT_I32_F32  = 7'd90;
    localparam logic [6:0] OP_CVT_I32_F64  = 7'd91;
    localparam logic [6:0] OP_COMP_F_F32   = 7'd92;

    // major opcodes
    localparam logic [5:0] MAJ_SPECIAL = 6'h00;
    localparam logic [5:0] MAJ_REGIMM  = 6'h01;
    localparam logic [5:0] MAJ_J       = 6'h02;
    localparam logic [5:0] MAJ_JAL     = 6'h03;
    localparam logic [5:0] MAJ_BEQ     = 6'h04;
    localparam logic [5:0] MAJ_BNE     = 6'h05;
    localparam logic [5:0] MAJ_BLEZ    = 6'h06;
    localparam logic [5:0] MAJ_BGTZ    = 6'h07;
    localparam logic [5:0] MAJ_COP1    = 6'h11;
    localparam logic [5:0] MAJ_RDHWR   = 6'h1f;
    localparam logic [5:0] MAJ_SB      = 6'h28;
    localparam logic [5:0] MAJ_SH      = 6'h29;
    localparam logic [5:0] MAJ_SWL     = 6'h2a;
    localparam logic [5:0] MAJ_SW      = 6'h2b;
    localparam logic [5:0] MAJ_SWR     = 6'h2e;
    localparam logic [5:0] MAJ_LL      = 6'h30;
    localparam logic [5:0] MAJ_LWC1    = 6'h31;
    localparam logic [5:0] MAJ_SC      = 6'h38;
    localparam logic [5:0] MAJ_SWC1    = 6'h39;

    localparam logic [4:0] FMT_S = 5'd16;
    localparam logic [4:0] FMT_D = 5'd17;
    localparam logic [4:0] FMT_W = 5'd20;

    localparam logic [5:0]  FN_RDHWR = 6'h3b;
    localparam logic [4:0]  HWR_TLS  = 5'd29;
    localparam logic [31:0] SEG_MASK = 32'hf000_0000;

    typedef struct packed {
        logic [6:0]  op;
        logic [4:0]  reg_s;
        logic [4:0]  reg_t;
        logic [4:0]  reg_d;
        logic [31:0] immediate;
        logic        is_branch;
        logic        ends_block;
    } iwd_result_t;

endpackage
`default_nettype wire

>>> src/iwd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module iwd_decode (
    input  wire logic [31:0]        pc,
    input  wire logic [31:0]        word,
    output iwd_pkg::iwd_result_t    result
);
    import iwd_pkg::*;

    logic [5:0]  major, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm16;
    logic [31:0] pc4, btarget, jtarget;
    logic [6:0]  op, sop, cop;
    logic        folds, dbl;
    logic [31:0] imm;
    logic [4:0]  out_s, out_d;

    assign major = word[31:26];
    assign rs    = word[25:21];
    assign rt    = word[20:16];
    assign rd    = word[15:11];
    assign sa    = word[10:6];
    assign fn    = word[5:0];
    assign imm16 = word[15:0];
    assign pc4   = pc + 32'd4;
    assign btarget = pc4 + {{14{imm16[15]}}, imm16, 2'b00};
    assign jtarget = (pc4 & SEG_MASK) + {4'd0, word[25:0], 2'b00};
    assign dbl   = (rs != FMT_S);

    // SPECIAL function decode
    always_comb begin
        folds = 1'b1;
        case (fn)
            6'h00: sop = OP_SLL;
            6'h02: sop = OP_SRL;
            6'h03: sop = OP_SRA;
            6'h04: sop = OP_SLLV;
            6'h06: sop = OP_SRLV;
            6'h07: sop = OP_SRAV;
            6'h08: begin sop = OP_JR; folds = 1'b0; end
            6'h09: begin sop = OP_JALR; folds = 1'b0; end
            6'h0c: begin sop = OP_SYSCALL; folds = 1'b0; end
            6'h0d: begin sop = OP_BREAK; folds = 1'b0; end
            6'h0f: begin sop = OP_SYNC; folds = 1'b0; end
            6'h10: begin sop = OP_MFHI; folds = 1'b0; end
            6'h11: begin sop = OP_MTHI; folds = 1'b0; end
            6'h12: sop = OP_MFLO;
            6'h13: begin sop = OP_MTLO; folds = 1'b0; end
            6'h18: begin sop = OP_MULT; folds = 1'b0; end
            6'h19: begin sop = OP_MULTU; folds = 1'b0; end
            6'h1a: begin sop = OP_DIV; folds = 1'b0; end
            6'h1b: begin sop = OP_DIVU; folds = 1'b0; end
            6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27:
                sop = OP_ADD + {4'd0, fn[2:0]};
            6'h2a: sop = OP_SLT;
            6'h2b: sop = OP_SLTU;
            default: begin sop = OP_INVALID; folds = 1'b0; end
        endcase
        if (folds && rd == 5'd0)
            sop = OP_NOP;
    end

    // COP1 function/format decode
    always_comb begin
        case (fn)
            6'h00: begin
                case (rs)
                    5'd0:    cop = OP_MFC1;
                    5'd2:    cop = OP_CFC1;
                    5'd4:    cop = OP_MTC1;
                    5'd6:    cop = OP_CTC1;
                    FMT_S:   cop = OP_ADD_F32;
                    FMT_D:   cop = OP_ADD_F64;
                    default: cop = OP_INVALID;
                endcase
            end
            6'h01, 6'h02, 6'h03:
                cop = OP_SUB_F32 + {4'd0, fn[1:0] - 2'd1, 1'b0} + {6'd0, dbl};
            6'h05, 6'h06, 6'h07:
                cop = OP_ABS_F32 + {4'd0, fn[1:0] - 2'd1, 1'b0} + {6'd0, dbl};
            6'h21: cop = (rs == FMT_S) ? OP_CVT_F64_F32 :
                         (rs == FMT_W) ? OP_CVT_F64_I32 : OP_INVALID;
            6'h20: cop = (rs == FMT_D) ? OP_CVT_F32_F64 :
                         (rs == FMT_W) ? OP_CVT_F32_I32 : OP_INVALID;
            6'h24: cop = (rs == FMT_S) ? OP_CVT_I32_F32 :
                         (rs == FMT_D) ? OP_CVT_I32_F64 : OP_INVALID;
            default: begin
                if (fn[5:4] == 2'b11)
                    cop = OP_COMP_F_F32 + {3'd0, fn[2:0], 1'b0} + {6'd0, dbl};
                else
                    cop = OP_INVALID;
            end
        endcase
    end

    // major opcode decode
    always_comb begin
        op    = OP_INVALID;
        imm   = 32'd0;
        out_s = rs;
        out_d = rd;
        case (major)
            MAJ_SPECIAL: begin
                op = sop;
                if (fn == 6'h00 || fn == 6'h02 || fn == 6'h03)
                    imm = {27'd0, sa};
                else if (fn == 6'h0c || fn == 6'h0d)
                    imm = {12'd0, word[25:6]};
            end
            MAJ_REGIMM: begin
                imm = btarget;
                case (rt)
                    5'd0:    op = (rs != 5'd0) ? OP_BLTZ : OP_NOP;
                    5'd1:    op = (rs != 5'd0) ? OP_BGEZ : OP_J;
                    5'd16:   op = (rs != 5'd0) ? OP_BLTZAL : OP_NOP;
                    5'd17:   op = (rs != 5'd0) ? OP_BGEZAL : OP_JAL;
                    default: op = OP_INVALID;
                endcase
            end
            MAJ_J:    begin imm = jtarget; op = OP_J; end
            MAJ_JAL:  begin imm = jtarget; op = OP_JAL; end
            MAJ_BEQ:  begin imm = btarget; op = (rs == rt) ? OP_J : OP_BEQ; end
            MAJ_BNE:  begin imm = btarget; op = (rs == rt) ? OP_NOP : OP_BNE; end
            MAJ_BLEZ: begin imm = btarget; op = (rs == 5'd0) ? OP_J : OP_BLEZ; end
            MAJ_BGTZ: begin imm = btarget; op = (rs == 5'd0) ? OP_NOP : OP_BGTZ; end
            MAJ_SB:   begin op = OP_SB;   imm = {16'd0, imm16}; end
            MAJ_SH:   begin op = OP_SH;   imm = {16'd0, imm16}; end
            MAJ_SWL:  begin op = OP_SWL;  imm = {16'd0, imm16}; end
            MAJ_SW:   begin op = OP_SW;   imm = {16'd0, imm16}; end
            MAJ_SWR:  begin op = OP_SWR;  imm = {16'd0, imm16}; end
            MAJ_SC:   begin op = OP_SC;   imm = {16'd0, imm16}; end
            MAJ_LL:   begin op = OP_LL;   imm = {16'd0, imm16}; end
            MAJ_SWC1: begin op = OP_SWC1; imm = {16'd0, imm16}; end
            MAJ_LWC1: begin op = OP_LWC1; imm = {16'd0, imm16}; end
            MAJ_RDHWR: begin
                if (fn == FN_RDHWR && rd == HWR_TLS)
                    op = OP_RDHWR_TLS;
            end
            MAJ_COP1: begin
                if (rs == 5'd8) begin
                    imm = btarget;
                    op  = word[16] ? OP_BC1T : OP_BC1F;
                end else begin
                    op    = cop;
                    out_s = rd;
                    out_d = sa;
                end
            end
            default: begin
                // immediate ALU 0x08..0x0f and loads 0x20..0x26
                if (major[5:3] == 3'b001) begin
                    imm = {16'd0, imm16};
                    op  = (rt == 5'd0) ? OP_NOP : OP_ADDI + {4'd0, major[2:0]};
                end else if (major[5:3] == 3'b100 && major[2:0] != 3'b111) begin
                    imm = {16'd0, imm16};
                    op  = (rt == 5'd0) ? OP_NOP :
                          OP_ADDI + 7'd8 + {4'd0, major[2:0]};
                end
            end
        endcase
    end

    // branch and block-end flags
    always_comb begin
        result.op        = op;
        result.reg_s     = out_s;
        result.reg_t     = rt;
        result.reg_d     = out_d;
        result.immediate = imm;
        result.is_branch = (op == OP_J) || (op == OP_JAL) || (op == OP_JR) ||
            (op == OP_JALR) || (op == OP_BEQ) || (op == OP_BNE) ||
            (op == OP_BLEZ) || (op == OP_BGTZ) || (op == OP_BLTZ) ||
            (op == OP_BGEZ) || (op == OP_BLTZAL) || (op == OP_BGEZAL) ||
            (op == OP_BC1F) || (op == OP_BC1T);
        result.ends_block = (op == OP_J) || (op == OP_JR) || (op == OP_BEQ) ||
            (op == OP_BNE) || (op == OP_BLEZ) || (op == OP_BGTZ) ||
            (op == OP_BLTZ) || (op == OP_BGEZ) || (op == OP_BC1F) ||
            (op == OP_BC1T) || (op == OP_BREAK) || (op == OP_INVALID);
    end

endmodule
`default_nettype wire

>>> src/instruction_word_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  tdata fields (low bit up)
// s_axis    in   pc[31:0], word[63:32]
// m_axis    out  op[6:0], reg_s, reg_t, reg_d, immediate[53:22], is_branch, ends_block
//
// A request passes through the input register, decode logic and result
// register. One request per cycle sustained while m_tready stays high; the
// decode stage advances whenever the result register is empty or being
// drained. aresetn clears both valid bits.
// With both registers full, a low m_tready drops s_tready in the same cycle.
module instruction_word_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // pc, word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // op, reg_s, reg_t, reg_d, immediate,
                                        // is_branch, ends_block
);
    import iwd_pkg::*;

    logic        in_valid_reg, out_valid_reg;
    logic [63:0] in_data_reg;
    iwd_result_t dec, out_reg;
    logic        out_ready, in_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    iwd_decode u_dec (
        .pc     (in_data_reg[31:0]),
        .word   (in_data_reg[63:32]),
        .result (dec)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_ready && s_tvalid)
            in_data_reg <= s_tdata;
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_ready && in_valid_reg)
            out_reg <= dec;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.ends_block, out_reg.is_branch, out_reg.immediate,
                       out_reg.reg_d, out_reg.reg_t, out_reg.reg_s, out_reg.op};

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import iwd_pkg::*;

    typedef struct packed {
        logic [6:0]  op;
        logic [4:0]  reg_s;
        logic [4:0]  reg_t;
        logic [4:0]  reg_d;
        logic [31:0] immediate;
        logic        is_branch;
        logic        ends_block;
    } decode_t;

    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    decode_t     decode_queue[$];
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    bit          calm = 1'b0;      // no idling on either side
    int          hold_cycles = 0;  // receiver hold-off request

    instruction_word_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // pc, word
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // op, reg_s, reg_t, reg_d, immediate, is_branch, ends_block
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] rel_target(logic [31:0] pc, logic [15:0] off);
        rel_target = pc + 32'd4 + {{14{off[15]}}, off, 2'b00};
    endfunction

    // Predicted decode of one instruction word
    function automatic decode_t decode_word(logic [31:0] pc, logic [31:0] w);
        decode_t     r;
        logic [5:0]  maj, fn;
        logic [4:0]  rs, rt, rd, sa;
        logic        dbl;
        bit          folds;
        maj = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
        sa = w[10:6]; fn = w[5:0];
        r = '0;
        r.op = OP_INVALID;
        case (maj)
            MAJ_SPECIAL: begin
                folds = 1'b1;
                case (fn)
                    6'h00: r.op = OP_SLL;
                    6'h02: r.op = OP_SRL;
                    6'h03: r.op = OP_SRA;
                    6'h04: r.op = OP_SLLV;
                    6'h06: r.op = OP_SRLV;
                    6'h07: r.op = OP_SRAV;
                    6'h08: begin r.op = OP_JR; folds = 0; end
                    6'h09: begin r.op = OP_JALR; folds = 0; end
                    6'h0c: begin r.op = OP_SYSCALL; folds = 0; end
                    6'h0d: begin r.op = OP_BREAK; folds = 0; end
                    6'h0f: begin r.op = OP_SYNC; folds = 0; end
                    6'h10: begin r.op = OP_MFHI; folds = 0; end
                    6'h11: begin r.op = OP_MTHI; folds = 0; end
                    6'h12: r.op = OP_MFLO;
                    6'h13: begin r.op = OP_MTLO; folds = 0; end
                    6'h18: begin r.op = OP_MULT; folds = 0; end
                    6'h19: begin r.op = OP_MULTU; folds = 0; end
                    6'h1a: begin r.op = OP_DIV; folds = 0; end
                    6'h1b: begin r.op = OP_DIVU; folds = 0; end
                    6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27:
                        r.op = OP_ADD + 7'(fn - 6'h20);
                    6'h2a: r.op = OP_SLT;
                    6'h2b: r.op = OP_SLTU;
                    default: folds = 0;
                endcase
                if (folds && rd == 5'd0) r.op = OP_NOP;
                if (fn == 6'h00 || fn == 6'h02 || fn == 6'h03) r.immediate = 32'(sa);
                else if (fn == 6'h0c || fn == 6'h0d) r.immediate = 32'(w[25:6]);
            end
            MAJ_REGIMM: begin
                r.immediate = rel_target(pc, w[15:0]);
                case (rt)
                    5'd0:  r.op = (rs != 0) ? OP_BLTZ : OP_NOP;
                    5'd1:  r.op = (rs != 0) ? OP_BGEZ : OP_J;
                    5'd16: r.op = (rs != 0) ? OP_BLTZAL : OP_NOP;
                    5'd17: r.op = (rs != 0) ? OP_BGEZAL : OP_JAL;
                    default: r.op = OP_INVALID;
                endcase
            end
            MAJ_J, MAJ_JAL: begin
                r.immediate = ((pc + 32'd4) & SEG_MASK) + {4'd0, w[25:0], 2'b00};
                r.op = (maj == MAJ_J) ? OP_J : OP_JAL;
            end
            MAJ_BEQ: begin
                r.immediate = rel_target(pc, w[15:0]);
                r.op = (rs == rt) ? OP_J : OP_BEQ;
            end
            MAJ_BNE: begin
                r.immediate = rel_target(pc, w[15:0]);
                r.op = (rs == rt) ? OP_NOP : OP_BNE;
            end
            MAJ_BLEZ: begin
                r.immediate = rel_target(pc, w[15:0]);
                r.op = (rs == 0) ? OP_J : OP_BLEZ;
            end
            MAJ_BGTZ: begin
                r.immediate = rel_target(pc, w[15:0]);
                r.op = (rs == 0) ? OP_NOP : OP_BGTZ;
            end
            MAJ_SB:   begin r.op = OP_SB;   r.immediate = 32'(w[15:0]); end
            MAJ_SH:   begin r.op = OP_SH;   r.immediate = 32'(w[15:0]); end
            MAJ_SWL:  begin r.op = OP_SWL;  r.immediate = 32'(w[15:0]); end
            MAJ_SW:   begin r.op = OP_SW;   r.immediate = 32'(w[15:0]); end
            MAJ_SWR:  begin r.op = OP_SWR;  r.immediate = 32'(w[15:0]); end
            MAJ_SC:   begin r.op = OP_SC;   r.immediate = 32'(w[15:0]); end
            MAJ_LL:   begin r.op = OP_LL;   r.immediate = 32'(w[15:0]); end
            MAJ_SWC1: begin r.op = OP_SWC1; r.immediate = 32'(w[15:0]); end
            MAJ_LWC1: begin r.op = OP_LWC1; r.immediate = 32'(w[15:0]); end
            MAJ_RDHWR: if (fn == FN_RDHWR && rd == HWR_TLS) r.op = OP_RDHWR_TLS;
            MAJ_COP1: begin
                if (rs == 5'd8) begin
                    r.immediate = rel_target(pc, w[15:0]);
                    r.op = w[16] ? OP_BC1T : OP_BC1F;
                end else begin
                    dbl = (rs != FMT_S);
                    case (fn)
                        6'h00: case (rs)
                            5'd0:  r.op = OP_MFC1;
                            5'd2:  r.op = OP_CFC1;
                            5'd4:  r.op = OP_MTC1;
                            5'd6:  r.op = OP_CTC1;
                            FMT_S: r.op = OP_ADD_F32;
                            FMT_D: r.op = OP_ADD_F64;
                            default: r.op = OP_INVALID;
                        endcase
                        6'h01, 6'h02, 6'h03:
                            r.op = OP_SUB_F32 + 7'(2 * (fn - 1)) + 7'(dbl);
                        6'h05, 6'h06, 6'h07:
                            r.op = OP_ABS_F32 + 7'(2 * (fn - 5)) + 7'(dbl);
                        6'h21: r.op = (rs == FMT_S) ? OP_CVT_F64_F32 :
                                      (rs == FMT_W) ? OP_CVT_F64_I32 : OP_INVALID;
                        6'h20: r.op = (rs == FMT_D) ? OP_CVT_F32_F64 :
                                      (rs == FMT_W) ? OP_CVT_F32_I32 : OP_INVALID;
                        6'h24: r.op = (rs == FMT_S) ? OP_CVT_I32_F32 :
                                      (rs == FMT_D) ? OP_CVT_I32_F64 : OP_INVALID;
                        default:
                            if (fn >= 6'h30)
                                r.op = OP_COMP_F_F32 + 7'(2 * fn[2:0]) + 7'(dbl);
                    endcase
                    rs = rd;
                    rd = sa;
                end
            end
            default: begin
                // immediate ALU 0x08..0x0f and loads 0x20..0x26
                if (maj >= 6'h08 && maj <= 6'h0f) begin
                    r.op = (rt == 0) ? OP_NOP : OP_ADDI + 7'(maj - 6'h08);
                    r.immediate = 32'(w[15:0]);
                end else if (maj >= 6'h20 && maj <= 6'h26) begin
                    r.op = (rt == 0) ? OP_NOP : OP_ADDI + 7'd8 + 7'(maj - 6'h20);
                    r.immediate = 32'(w[15:0]);
                end
            end
        endcase
        r.reg_s = rs; r.reg_t = rt; r.reg_d = rd;
        r.is_branch = r.op inside {OP_J, OP_JAL, OP_JR, OP_JALR, OP_BEQ, OP_BNE,
            OP_BLEZ, OP_BGTZ, OP_BLTZ, OP_BGEZ, OP_BLTZAL, OP_BGEZAL, OP_BC1F, OP_BC1T};
        r.ends_block = r.op inside {OP_J, OP_JR, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
            OP_BLTZ, OP_BGEZ, OP_BC1F, OP_BC1T, OP_BREAK, OP_INVALID};
        return r;
    endfunction

    // Send one request; idles at random first unless calm
    task automatic send_word(logic [31:0] pc, logic [31:0] w);
        while (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, pc};
        decode_queue.push_back(decode_word(pc, w));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_done();
        s_tvalid <= 1'b0;
    endtask

    // Receiver ready: random idling, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        decode_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.op         = m_tdata[6:0];
            got.reg_s      = m_tdata[11:7];
            got.reg_t      = m_tdata[16:12];
            got.reg_d      = m_tdata[21:17];
            got.immediate  = m_tdata[53:22];
            got.is_branch  = m_tdata[54];
            got.ends_block = m_tdata[55];
            if (decode_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                err_cnt++;
            end else begin
                want = decode_queue.pop_front();
                if (got.op !== want.op) begin
                    $display("%0t: op exp %0d got %0d", $time, want.op, got.op); err_cnt++;
                end
                if (got.reg_s !== want.reg_s) begin
                    $display("%0t: reg_s exp %0d got %0d", $time, want.reg_s, got.reg_s);
                    err_cnt++;
                end
                if (got.reg_t !== want.reg_t) begin
                    $display("%0t: reg_t exp %0d got %0d", $time, want.reg_t, got.reg_t);
                    err_cnt++;
                end
                if (got.reg_d !== want.reg_d) begin
                    $display("%0t: reg_d exp %0d got %0d", $time, want.reg_d, got.reg_d);
                    err_cnt++;
                end
                if (got.immediate !== want.immediate) begin
                    $display("%0t: immediate exp %h got %h", $time, want.immediate,
                             got.immediate);
                    err_cnt++;
                end
                if (got.is_branch !== want.is_branch) begin
                    $display("%0t: is_branch exp %b got %b", $time, want.is_branch,
                             got.is_branch);
                    err_cnt++;
                end
                if (got.ends_block !== want.ends_block) begin
                    $display("%0t: ends_block exp %b got %b", $time, want.ends_block,
                             got.ends_block);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[instruction_word_decoder_core] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        logic [5:0]  majors[20];
        majors = '{MAJ_SPECIAL, MAJ_REGIMM, MAJ_J, MAJ_JAL, MAJ_BEQ, MAJ_BNE, MAJ_BLEZ,
                   MAJ_BGTZ, MAJ_COP1, MAJ_RDHWR, MAJ_SB, MAJ_SW, MAJ_LL, MAJ_SC,
                   MAJ_LWC1, MAJ_SWC1, 6'h08, 6'h0f, 6'h20, 6'h26};
        w = $urandom;
        case ($urandom_range(9))
            0, 1, 2: w[31:26] = majors[$urandom_range(19)];
            3: begin w[31:26] = MAJ_SPECIAL; w[10:6] = $urandom_range(1) ? 5'd0 : w[10:6]; end
            4: begin w[31:26] = MAJ_COP1; w[25:21] = $urandom_range(1) ? FMT_S : FMT_D; end
            5: begin w[31:26] = MAJ_COP1; w[25:21] = $urandom_range(1) ? FMT_W : 5'd8; end
            6: begin w[31:26] = MAJ_REGIMM; w[20:16] = $urandom_range(1) ? 5'd0 : 5'd17;
                  if ($urandom_range(1)) w[25:21] = 0; end
            7: begin
                w[31:26] = 6'(4 + $urandom_range(3));
                if ($urandom_range(1)) w[20:16] = w[25:21];
            end
            8: begin w[31:26] = MAJ_RDHWR; w[5:0] = FN_RDHWR; w[15:11] = HWR_TLS; end
            default: ;
        endcase
        if ($urandom_range(5) == 0) w[15:11] = 0;
        if ($urandom_range(5) == 0) w[20:16] = 0;
        return w;
    endfunction

    task automatic wait_drain();
        while (decode_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_word(32'h0, 32'h0);                       // SLL to r0 -> NOP
        send_word(32'hffff_fffc, 32'h1000_ffff);       // BEQ trivially taken, wrap
        send_word(32'h0000_0000, 32'h1400_8000);       // BNE rs=rt -> NOP
        send_word(32'h1234_5678, 32'h1881_0001);       // BLEZ
        send_word(32'h0fff_fffc, 32'h0bff_ffff);       // J across segment
        send_word(32'h0, 32'h0c00_0000);               // JAL
        send_word(32'h8000_0000, 32'h0411_7fff);       // BGEZAL rs=0 -> JAL
        send_word(32'h8000_0000, 32'h0430_0004);       // BLTZAL
        send_word(32'h0, 32'h0412_0000);               // REGIMM unknown
        send_word(32'h0, 32'h0000_000d);               // BREAK
        send_word(32'h0, 32'hffff_ffcc);               // SYSCALL-ish major 0x3f invalid
        send_word(32'h0, 32'h03ff_ffcc);               // SYSCALL code
        send_word(32'h0, 32'h2000_1234);               // ADDI rt=0 -> NOP
        send_word(32'h0, 32'h8c22_ffff);               // LW
        send_word(32'h0, 32'hc000_0001);               // LL rt=0 stays
        send_word(32'h0, 32'h7c03_e83b);               // RDHWR TLS
        send_word(32'h0, 32'h7c03_e03b);               // RDHWR other -> invalid
        send_word(32'h0, 32'h4600_0000);               // ADD.S
        send_word(32'h0, 32'h46a0_0020);               // CVT.S, fmt 21 -> invalid
        send_word(32'h0, 32'h4660_0020);               // CVT bad fmt
        send_word(32'h0, 32'h4621_003f);               // compare double
        send_word(32'h0, 32'h4501_0010);               // BC1T
        send_word(32'h0, 32'h4440_0000);               // CFC1
        send_word(32'h0, 32'h0000_f827);               // NOR
        send_done();
        wait_drain();
    endtask

    task automatic test_random(int n);
        repeat (n) send_word($urandom, rand_word());
        send_done();
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_cycles <= 60;
        repeat (40) send_word($urandom, rand_word());
        send_done();
        wait_drain();
    endtask

    task automatic test_full_rate();
        calm = 1'b1;
        repeat (150) send_word($urandom, rand_word());
        send_done();
        wait_drain();
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(450);
        test_backpressure();
        test_full_rate();
        test_random(200);
        repeat (10) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("[instruction_word_decoder_core] OK");
        end else begin
            $display("[instruction_word_decoder_core] ERROR");
        end
        $finish;
    end
endmodule
